// ----- rtl/core/tmc_pkg.sv -----
package tmc_pkg;

    // map geometry
    localparam int MAP_WIDTH  = 128;
    localparam int MAP_HEIGHT = 64;
    localparam int X_W        = $clog2(MAP_WIDTH);
    localparam int Y_W        = $clog2(MAP_HEIGHT);
    localparam int ADDR_W     = $clog2(MAP_WIDTH * MAP_HEIGHT);
    localparam int MAP_DEPTH  = MAP_WIDTH * MAP_HEIGHT;

    // field widths
    localparam int POS_W   = 11;
    localparam int COORD_W = POS_W + 1;
    localparam int RAD_W   = 6;
    localparam int D_W     = RAD_W + 1;
    localparam int SQ_W    = 2 * RAD_W;
    localparam int TILE_W  = 2;
    localparam int OP_W    = 2;

    // operation codes
    localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
    localparam logic [OP_W-1:0] OP_READ    = 2'd1;
    localparam logic [OP_W-1:0] OP_DESTROY = 2'd2;

    // tile codes
    localparam logic [TILE_W-1:0] TILE_CLEAR = 2'd0;
    localparam logic [TILE_W-1:0] TILE_SOIL  = 2'd1;

    // one visited cell of a destroy sweep
    typedef struct packed {
        logic              valid;
        logic              hit;
        logic              last;
        logic [ADDR_W-1:0] addr;
    } scan_cell_t;

    function automatic logic in_map(input logic signed [COORD_W-1:0] x,
                                    input logic signed [COORD_W-1:0] y);
        in_map = (x >= 0) && (x < $signed(COORD_W'(MAP_WIDTH)))
              && (y >= 0) && (y < $signed(COORD_W'(MAP_HEIGHT)));
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic signed [COORD_W-1:0] x,
                                                    input logic signed [COORD_W-1:0] y);
        logic [X_W-1:0] xi;
        logic [Y_W-1:0] yi;
        xi = x[X_W-1:0];
        yi = y[Y_W-1:0];
        cell_addr = ADDR_W'(yi * MAP_WIDTH) + ADDR_W'(xi);
    endfunction

endpackage

// ----- rtl/core/tile_map_circle_clear.sv -----
// tile map with circle clear. a command word is taken at a rising edge where start is high
// and busy is low. a write gives no result. a read gives its tile on tile_out with done
// high for exactly one cycle, the cycle after it was taken, and the next command is
// taken at the earliest on the edge that ends the cycle after done; there is no way to
// hold the result off, so capture it on done. a destroy sweeps its (2r+1)^2 bounding
// square at one cell per cycle through the single read port of the map memory, then
// finishes the last write in a drain state before busy falls. the map has no reset:
// read only cells that have been written.
module tile_map_circle_clear import tmc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [OP_W-1:0]          op,
    input  logic signed [POS_W-1:0]  pos_x,
    input  logic signed [POS_W-1:0]  pos_y,
    input  logic [TILE_W-1:0]        tile_in,
    input  logic [RAD_W-1:0]         radius,
    output logic                     done,
    output logic [TILE_W-1:0]        tile_out
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RESP,
        ST_SCAN,
        ST_DRAIN
    } state_t;

    state_t state_reg, state_next;

    // map storage, one read port and one write port
    logic [TILE_W-1:0] map_mem [MAP_DEPTH];
    logic [TILE_W-1:0] rdata_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [TILE_W-1:0] wr_data;

    // read result qualifier
    logic rd_ok_reg, rd_ok_next;

    // cell whose data arrives this cycle during a sweep
    logic              pend_hit_reg, pend_hit_next;
    logic [ADDR_W-1:0] pend_addr_reg;

    logic                      accept;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic                      pos_ok;
    logic [ADDR_W-1:0]         pos_addr;
    logic                      scan_go;
    scan_cell_t                scan_cell;

    assign busy     = (state_reg != ST_IDLE);
    assign accept   = start && !busy;
    assign px       = COORD_W'(pos_x);
    assign py       = COORD_W'(pos_y);
    assign pos_ok   = in_map(px, py);
    assign pos_addr = cell_addr(px, py);
    assign scan_go  = accept && (op == OP_DESTROY);

    tmc_scan u_scan
    (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (scan_go),
        .cx    (pos_x),
        .cy    (pos_y),
        .r     (radius),
        .sweep (scan_cell)
    );

    // read address: sweep cell while scanning, command position otherwise
    assign rd_addr = (state_reg == ST_SCAN) ? scan_cell.addr : pos_addr;

    // write: plain tile write, or ground to empty on the previous sweep cell
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = pos_addr;
        wr_data = tile_in;
        if (accept && (op == OP_WRITE) && pos_ok)
        begin
            wr_en = 1'b1;
        end
        else if (((state_reg == ST_SCAN) || (state_reg == ST_DRAIN))
                 && pend_hit_reg && (rdata_reg == TILE_SOIL))
        begin
            wr_en   = 1'b1;
            wr_addr = pend_addr_reg;
            wr_data = TILE_CLEAR;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            map_mem[wr_addr] <= wr_data;
        end
        rdata_reg     <= map_mem[rd_addr];
        pend_addr_reg <= scan_cell.addr;
    end

    always_comb
    begin
        state_next    = state_reg;
        rd_ok_next    = rd_ok_reg;
        pend_hit_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (op)
                        OP_READ:
                        begin
                            state_next = ST_RESP;
                            rd_ok_next = pos_ok;
                        end
                        OP_DESTROY:
                        begin
                            state_next = ST_SCAN;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_RESP:
            begin
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                pend_hit_next = scan_cell.hit;
                if (scan_cell.last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            rd_ok_reg    <= 1'b0;
            pend_hit_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_ok_reg    <= rd_ok_next;
            pend_hit_reg <= pend_hit_next;
        end
    end

    // result word: out-of-range reads give empty
    assign done     = (state_reg == ST_RESP);
    assign tile_out = rd_ok_reg ? rdata_reg : TILE_CLEAR;

    // a sweep only runs while the sequencer is scanning
    a_scan_in_state: assert property (@(posedge clk) disable iff (!rst_n)
        scan_cell.valid |-> (state_reg == ST_SCAN))
        else $error("sweep cell outside scan state");

    // a sweep write only ever turns ground into empty
    a_clear_ground_only: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en && ((state_reg == ST_SCAN) || (state_reg == ST_DRAIN))
        |-> (rdata_reg == TILE_SOIL) && (wr_data == TILE_CLEAR))
        else $error("sweep wrote a non-ground cell");

    // every accepted read gives its word on the next cycle
    a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (op == OP_READ) |=> done)
        else $error("read result missing");

    // results are single-cycle strobes
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

endmodule

// ----- rtl/core/tmc_scan.sv -----
module tmc_scan import tmc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      go,
    input  logic signed [POS_W-1:0]   cx,
    input  logic signed [POS_W-1:0]   cy,
    input  logic        [RAD_W-1:0]   r,
    output scan_cell_t                sweep
);

    logic                      active_reg, active_next;
    logic signed [COORD_W-1:0] x_reg, x_next;
    logic signed [COORD_W-1:0] y_reg, y_next;
    logic signed [COORD_W-1:0] x0_reg, x0_next;
    logic signed [D_W-1:0]     dx_reg, dx_next;
    logic signed [D_W-1:0]     dy_reg, dy_next;
    logic        [RAD_W-1:0]   r_reg, r_next;
    logic        [SQ_W-1:0]    dxsq_reg, dxsq_next;
    logic        [SQ_W-1:0]    dysq_reg, dysq_next;
    logic        [SQ_W-1:0]    rsq_reg, rsq_next;

    logic signed [D_W-1:0]     r_s;
    logic                      row_end;
    logic                      sweep_end;
    logic [SQ_W:0]             dsq_sum;
    logic        [SQ_W-1:0]    step_sq;
    logic signed [D_W-1:0]     step_d;
    logic [SQ_W+1:0]           step_sum;
    logic [SQ_W-1:0]           r_sq;

    assign r_s       = $signed({1'b0, r_reg});
    assign row_end   = (dx_reg == r_s);
    assign sweep_end = row_end && (dy_reg == r_s);
    assign dsq_sum   = {1'b0, dxsq_reg} + {1'b0, dysq_reg};
    assign r_sq      = SQ_W'({{RAD_W{1'b0}}, r} * {{RAD_W{1'b0}}, r});

    // shared square stepper: (d+1)^2 = d^2 + 2d + 1, on dy at a row end, else on dx
    assign step_sq  = row_end ? dysq_reg : dxsq_reg;
    assign step_d   = row_end ? dy_reg : dx_reg;
    assign step_sum = {2'b00, step_sq}
                    + {{(SQ_W+1-D_W){step_d[D_W-1]}}, step_d, 1'b0}
                    + (SQ_W+2)'(1);

    always_comb
    begin
        active_next = active_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        x0_next     = x0_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        r_next      = r_reg;
        dxsq_next   = dxsq_reg;
        dysq_next   = dysq_reg;
        rsq_next    = rsq_reg;
        if (go)
        begin
            active_next = 1'b1;
            r_next      = r;
            x0_next     = COORD_W'(cx) - $signed({{(COORD_W-RAD_W){1'b0}}, r});
            x_next      = COORD_W'(cx) - $signed({{(COORD_W-RAD_W){1'b0}}, r});
            y_next      = COORD_W'(cy) - $signed({{(COORD_W-RAD_W){1'b0}}, r});
            dx_next     = -$signed({1'b0, r});
            dy_next     = -$signed({1'b0, r});
            dxsq_next   = r_sq;
            dysq_next   = r_sq;
            rsq_next    = r_sq;
        end
        else if (active_reg)
        begin
            if (sweep_end)
            begin
                active_next = 1'b0;
            end
            else if (row_end)
            begin
                x_next    = x0_reg;
                dx_next   = -r_s;
                dxsq_next = rsq_reg;
                y_next    = y_reg + COORD_W'(1);
                dy_next   = dy_reg + D_W'(1);
                dysq_next = step_sum[SQ_W-1:0];
            end
            else
            begin
                x_next    = x_reg + COORD_W'(1);
                dx_next   = dx_reg + D_W'(1);
                dxsq_next = step_sum[SQ_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        x0_reg   <= x0_next;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        r_reg    <= r_next;
        dxsq_reg <= dxsq_next;
        dysq_reg <= dysq_next;
        rsq_reg  <= rsq_next;
    end

    assign sweep.valid = active_reg;
    assign sweep.hit   = active_reg && in_map(x_reg, y_reg) && (dsq_sum <= {1'b0, rsq_reg});
    assign sweep.last  = active_reg && sweep_end;
    assign sweep.addr  = cell_addr(x_reg, y_reg);

endmodule

// ----- tb/tile_map_circle_clear_test.sv -----
module tile_map_circle_clear_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tmc_pkg::*;

    // codes the package leaves unnamed
    localparam logic [OP_W-1:0]   OP_SPARE   = 2'd3;
    localparam logic [TILE_W-1:0] TILE_ROCK  = 2'd2;
    localparam logic [TILE_W-1:0] TILE_SPARE = 2'd3;

    // random part and the point at which the sender holds off until all reads are back
    localparam int RANDOM_WORDS = 165;
    localparam int HOLD_AT      = 80;

    // patches that get tiles: a square at the origin and a smaller one at the far corner
    localparam int LOAD_W = 16;
    localparam int LOAD_H = 16;
    localparam int CORNER = 8;

    logic                    clk      = 1'b0;
    logic                    rst_n    = 1'b0;
    logic                    start    = 1'b0;
    logic                    busy;
    logic [OP_W-1:0]         op       = OP_WRITE;
    logic signed [POS_W-1:0] pos_x    = '0;
    logic signed [POS_W-1:0] pos_y    = '0;
    logic [TILE_W-1:0]       tile_in  = TILE_CLEAR;
    logic [RAD_W-1:0]        radius   = '0;
    logic                    done;
    logic [TILE_W-1:0]       tile_out;

    // our own copy of the map, and the tiles that reads have still to return, oldest first
    logic [TILE_W-1:0] map_model [MAP_DEPTH];
    logic [TILE_W-1:0] tiles_due [$];

    int fail_count = 0;
    int burst_left = 1;

    tile_map_circle_clear i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .op       (op),
        .pos_x    (pos_x),
        .pos_y    (pos_y),
        .tile_in  (tile_in),
        .radius   (radius),
        .done     (done),
        .tile_out (tile_out)
    );

    // 4 ns period
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // hard stop in case the block hangs: several times a run of nothing but full-size sweeps
    initial
    begin
        #200_000_000;
        $display("tile_map_circle_clear_test failed");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch: %s", what);
        fail_count++;
    endtask

    // ------------------------------------------------------------------
    // map predictor
    // ------------------------------------------------------------------

    function automatic bit on_map(input int x, input int y);
        return x >= 0 && x < MAP_WIDTH && y >= 0 && y < MAP_HEIGHT;
    endfunction

    function automatic int map_index(input int x, input int y);
        return y * MAP_WIDTH + x;
    endfunction

    // a cell may be read or swept once it holds a tile; off-map cells are never touched
    function automatic bit cell_known(input int x, input int y);
        if (!on_map(x, y))
            return 1'b1;
        return !$isunknown(map_model[map_index(x, y)]);
    endfunction

    function automatic bit square_known(input int cx, input int cy, input int r);
        int xx;
        int yy;
        for (yy = cy - r; yy <= cy + r; yy++)
            for (xx = cx - r; xx <= cx + r; xx++)
                if (!cell_known(xx, yy))
                    return 1'b0;
        return 1'b1;
    endfunction

    // applies one accepted word to the map copy; a read queues the tile it must return
    function automatic void apply_to_map(input logic [OP_W-1:0] w_op,
                                         input logic signed [POS_W-1:0] w_x,
                                         input logic signed [POS_W-1:0] w_y,
                                         input logic [TILE_W-1:0] w_tile,
                                         input logic [RAD_W-1:0] w_rad);
        int cx;
        int cy;
        int r;
        int xx;
        int yy;
        cx = int'(w_x);
        cy = int'(w_y);
        r  = int'(w_rad);
        case (w_op)
            OP_WRITE:
            begin
                if (on_map(cx, cy))
                    map_model[map_index(cx, cy)] = w_tile;
            end
            OP_READ:
            begin
                if (on_map(cx, cy))
                    tiles_due.push_back(map_model[map_index(cx, cy)]);
                else
                    tiles_due.push_back(TILE_CLEAR);
            end
            OP_DESTROY:
            begin
                // only ground inside the disc turns to empty; off-map cells are skipped
                for (yy = cy - r; yy <= cy + r; yy++)
                    for (xx = cx - r; xx <= cx + r; xx++)
                        if (on_map(xx, yy)
                            && (xx - cx) * (xx - cx) + (yy - cy) * (yy - cy) <= r * r
                            && map_model[map_index(xx, yy)] == TILE_SOIL)
                            map_model[map_index(xx, yy)] = TILE_CLEAR;
            end
            default: ; // spare op code does nothing
        endcase
    endfunction

    // ------------------------------------------------------------------
    // sender
    // ------------------------------------------------------------------

    // bursts of random length, then a random gap with start low
    task automatic pace_sender();
        int gap;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60)
                                                      : $urandom_range(1, 12);
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // offers one command word and waits until it is taken; busy is looked at on the
    // falling edge, so the rising edge that follows is the one that takes the word
    task automatic send_word(input logic [OP_W-1:0] w_op,
                             input logic signed [POS_W-1:0] w_x,
                             input logic signed [POS_W-1:0] w_y,
                             input logic [TILE_W-1:0] w_tile,
                             input logic [RAD_W-1:0] w_rad);
        bit taken;
        start   <= 1'b1;
        op      <= w_op;
        pos_x   <= w_x;
        pos_y   <= w_y;
        tile_in <= w_tile;
        radius  <= w_rad;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = (busy === 1'b0);
            @(posedge clk);
        end
        apply_to_map(w_op, w_x, w_y, w_tile, w_rad);
        pace_sender();
    endtask

    // sender stands still until every read issued so far has come back
    task automatic hold_until_drained();
        start <= 1'b0;
        while (tiles_due.size() != 0)
            @(posedge clk);
        @(posedge clk);
        burst_left = 1;
    endtask

    // ------------------------------------------------------------------
    // random field choices
    // ------------------------------------------------------------------

    // mostly on the map, some just over an edge, some anywhere in the 11-bit range
    function automatic logic signed [POS_W-1:0] pick_pos(input int span);
        logic signed [POS_W-1:0] p;
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 82)
            p = POS_W'($urandom_range(0, span - 1));
        else if (sel < 92)
        begin
            case ($urandom_range(0, 3))
                0:       p = POS_W'(-1);
                1:       p = POS_W'(span);
                2:       p = '0;
                default: p = POS_W'(span - 1);
            endcase
        end
        else
            p = POS_W'($urandom);
        return p;
    endfunction

    // a read position or sweep centre on a loaded cell, just over an edge, or off the map
    function automatic void pick_target(output logic signed [POS_W-1:0] tx,
                                        output logic signed [POS_W-1:0] ty);
        do
        begin
            tx = pick_pos(LOAD_W);
            ty = pick_pos(LOAD_H);
        end
        while (!cell_known(int'(tx), int'(ty)));
    endfunction

    // plenty of ground so that destroys have something to clear
    function automatic logic [TILE_W-1:0] pick_tile();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 45)
            return TILE_SOIL;
        else if (sel < 65)
            return TILE_ROCK;
        else if (sel < 90)
            return TILE_CLEAR;
        return TILE_SPARE;
    endfunction

    // small radii keep the sweep short; a few large ones reach the top bit
    function automatic logic [RAD_W-1:0] pick_radius();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 76)
            return RAD_W'($urandom_range(0, 6));
        else if (sel < 96)
            return RAD_W'($urandom_range(7, 15));
        else if (sel < 99)
            return RAD_W'($urandom_range(16, 31));
        return RAD_W'($urandom_range(32, 63));
    endfunction

    // ------------------------------------------------------------------
    // result checker: done is high for exactly one cycle, sampled mid-cycle
    // ------------------------------------------------------------------

    always @(negedge clk)
    begin : check_reads
        logic [TILE_W-1:0] want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (tiles_due.size() == 0)
                report_mismatch($sformatf("read result %0d with no read pending", tile_out));
            else
            begin
                want = tiles_due.pop_front();
                if (tile_out !== want)
                    report_mismatch($sformatf("tile_out %0d, wanted %0d", tile_out, want));
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // the map has no reset: two patches get tiles, and reads and sweeps keep to them
    task automatic load_map();
        int x;
        int y;
        for (y = 0; y < LOAD_H; y++)
            for (x = 0; x < LOAD_W; x++)
                send_word(OP_WRITE, POS_W'(x), POS_W'(y), pick_tile(), RAD_W'($urandom));
        for (y = MAP_HEIGHT - CORNER; y < MAP_HEIGHT; y++)
            for (x = MAP_WIDTH - CORNER; x < MAP_WIDTH; x++)
                send_word(OP_WRITE, POS_W'(x), POS_W'(y), pick_tile(), RAD_W'($urandom));
    endtask

    // corners, off-map writes and reads, the spare tile and op codes
    task automatic test_edges();
        send_word(OP_WRITE, POS_W'(0), POS_W'(0), TILE_SOIL, RAD_W'(0));
        send_word(OP_READ, POS_W'(0), POS_W'(0), TILE_CLEAR, RAD_W'(0));
        send_word(OP_WRITE, POS_W'(MAP_WIDTH - 1), POS_W'(MAP_HEIGHT - 1), TILE_ROCK,
                  RAD_W'(63));
        send_word(OP_READ, POS_W'(MAP_WIDTH - 1), POS_W'(MAP_HEIGHT - 1), TILE_SPARE,
                  RAD_W'(63));
        send_word(OP_WRITE, POS_W'(5), POS_W'(5), TILE_SPARE, RAD_W'(0));
        send_word(OP_READ, POS_W'(5), POS_W'(5), TILE_CLEAR, RAD_W'(0));
        // off-map writes must not land on an aliased cell
        send_word(OP_WRITE, POS_W'(-1), POS_W'(0), TILE_ROCK, RAD_W'(0));
        send_word(OP_WRITE, POS_W'(MAP_WIDTH), POS_W'(10), TILE_ROCK, RAD_W'(0));
        send_word(OP_READ, POS_W'(-1), POS_W'(0), TILE_CLEAR, RAD_W'(0));
        send_word(OP_READ, POS_W'(MAP_WIDTH), POS_W'(10), TILE_CLEAR, RAD_W'(0));
        send_word(OP_READ, POS_W'(10), POS_W'(MAP_HEIGHT), TILE_CLEAR, RAD_W'(0));
        send_word(OP_READ, POS_W'(-1024), POS_W'(-1024), TILE_SPARE, RAD_W'(63));
        send_word(OP_READ, POS_W'(1023), POS_W'(1023), TILE_SPARE, RAD_W'(63));
        send_word(OP_READ, POS_W'(0), POS_W'(10), TILE_CLEAR, RAD_W'(0));
        // spare op code is a no-op
        send_word(OP_SPARE, POS_W'(0), POS_W'(0), TILE_CLEAR, RAD_W'(63));
        send_word(OP_READ, POS_W'(0), POS_W'(0), TILE_CLEAR, RAD_W'(0));
    endtask

    // single-cell, corner, full-size and off-map sweeps
    task automatic test_destroy_cases();
        send_word(OP_DESTROY, POS_W'(0), POS_W'(0), TILE_SPARE, RAD_W'(0));
        send_word(OP_READ, POS_W'(0), POS_W'(0), TILE_CLEAR, RAD_W'(0));
        send_word(OP_DESTROY, POS_W'(MAP_WIDTH - 1), POS_W'(MAP_HEIGHT - 1), TILE_CLEAR,
                  RAD_W'(1));
        send_word(OP_READ, POS_W'(MAP_WIDTH - 1), POS_W'(MAP_HEIGHT - 1), TILE_CLEAR,
                  RAD_W'(0));
        send_word(OP_DESTROY, POS_W'(8), POS_W'(8), TILE_CLEAR, RAD_W'(7));
        send_word(OP_READ, POS_W'(8), POS_W'(8), TILE_CLEAR, RAD_W'(0));
        send_word(OP_READ, POS_W'(5), POS_W'(5), TILE_CLEAR, RAD_W'(0));
        send_word(OP_READ, POS_W'(MAP_WIDTH - 1), POS_W'(MAP_HEIGHT - CORNER), TILE_CLEAR,
                  RAD_W'(0));
        // centre just off the corner, bounding square reaching over the whole origin patch
        send_word(OP_DESTROY, POS_W'(-1), POS_W'(-1), TILE_CLEAR, RAD_W'(16));
        send_word(OP_READ, POS_W'(3), POS_W'(3), TILE_CLEAR, RAD_W'(0));
        send_word(OP_DESTROY, POS_W'(-1024), POS_W'(-1024), TILE_CLEAR, RAD_W'(63));
        send_word(OP_DESTROY, POS_W'(1023), POS_W'(1023), TILE_SOIL, RAD_W'(5));
    endtask

    // mostly well-formed traffic on the map, some reads round each sweep, some noise
    task automatic test_random_traffic();
        int n;
        int k;
        int sel;
        logic [OP_W-1:0]         w_op;
        logic signed [POS_W-1:0] cx;
        logic signed [POS_W-1:0] cy;
        logic [RAD_W-1:0]        r;
        for (n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n == HOLD_AT)
                hold_until_drained();
            sel = $urandom_range(0, 99);
            if (sel < 35)
                send_word(OP_WRITE, pick_pos(MAP_WIDTH), pick_pos(MAP_HEIGHT), pick_tile(),
                          RAD_W'($urandom));
            else if (sel < 72)
            begin
                pick_target(cx, cy);
                send_word(OP_READ, cx, cy, TILE_W'($urandom), RAD_W'($urandom));
            end
            else if (sel < 92)
            begin
                pick_target(cx, cy);
                r = pick_radius();
                // pull the radius in until the square covers only loaded or off-map cells
                while (r != '0 && !square_known(int'(cx), int'(cy), int'(r)))
                    r--;
                send_word(OP_DESTROY, cx, cy, TILE_W'($urandom), r);
                // look at a few cells of the bounding square straight away
                if ($urandom_range(0, 9) < 4)
                    for (k = 0; k < 3; k++)
                        send_word(OP_READ, cx + POS_W'($urandom_range(0, 2 * r)) - r,
                                  cy + POS_W'($urandom_range(0, 2 * r)) - r,
                                  TILE_W'($urandom), RAD_W'($urandom));
            end
            else if (sel < 96)
                send_word(OP_SPARE, POS_W'($urandom), POS_W'($urandom), TILE_W'($urandom),
                          RAD_W'($urandom));
            else
            begin
                // any word at all, kept off the slowest sweeps and off cells with no tile
                w_op = OP_W'($urandom);
                cx   = POS_W'($urandom);
                cy   = POS_W'($urandom);
                r    = RAD_W'($urandom_range(0, 15));
                if (((w_op == OP_READ) && !cell_known(int'(cx), int'(cy)))
                    || ((w_op == OP_DESTROY) && !square_known(int'(cx), int'(cy), int'(r))))
                    w_op = OP_SPARE;
                send_word(w_op, cx, cy, TILE_W'($urandom), r);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial
    begin
        int waited;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_map();
        test_edges();
        test_destroy_cases();
        test_random_traffic();

        // let the last reads come home, allowing for a full-size sweep still running
        start <= 1'b0;
        waited = 0;
        while (tiles_due.size() != 0 && waited < 40000)
        begin
            @(posedge clk);
            waited++;
        end
        while (tiles_due.size() != 0)
            report_mismatch($sformatf("read never answered, tile %0d",
                                      tiles_due.pop_front()));
        repeat (8) @(posedge clk);

        if (fail_count == 0)
            $display("tile_map_circle_clear_test passed");
        else
            $display("tile_map_circle_clear_test failed");
        $finish;
    end

endmodule
